[src/imp_pkg.sv]
// shared constants, types and log table helpers for the image mse/psnr block
package imp_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;
	localparam logic [14:0] PSNR_IDENTICAL_Q8 = 15'd25600;
	localparam logic [14:0] PSNR_MAX_Q8       = 15'd32767;

	typedef struct packed {
		logic empty;
		logic room;
	} queue_stat_t;

	// log2 of a Q2.30 mantissa in [1,2), fraction in Q0.16, truncated
	function automatic logic [15:0] mant_log2(input logic [63:0] m_in);
		logic [63:0] m;
		logic [15:0] r;
		m = m_in;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			r = r << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] table_entry(input int k, input int tbits);
		logic [63:0] m;
		m = ((64'd1 << tbits) + 64'(k)) << (30 - tbits);
		return mant_log2(m);
	endfunction

	// log2(255^2) + 16, in Q16
	localparam logic [20:0] LOG_TOP_Q16 =
		21'(32'd15 * 32'd65536 + 32'(mant_log2(64'd65025 << 15)) + 32'd16 * 32'd65536);

endpackage

[src/imp_if.sv]
// pixel pair and result channel interfaces
interface imp_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_blue;
	logic [7:0] first_green;
	logic [7:0] first_red;
	logic [7:0] second_blue;
	logic [7:0] second_green;
	logic [7:0] second_red;
	logic       last_pixel;
	modport source(output valid, first_blue, first_green, first_red, second_blue,
		second_green, second_red, last_pixel, input ready);
	modport sink(input valid, first_blue, first_green, first_red, second_blue,
		second_green, second_red, last_pixel, output ready);
endinterface

interface imp_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] mse_q16;
	logic [14:0] psnr_q8;
	logic        identical;
	logic        count_overflow;
	modport source(output valid, mse_q16, psnr_q8, identical, count_overflow,
		input ready);
	modport sink(input valid, mse_q16, psnr_q8, identical, count_overflow,
		output ready);
endinterface

[src/image_mse_psnr.sv]
// top level of the image mse/psnr block
//   channel  dir  handshake         payload
//   pix      in   valid/ready       two rgb pixels, last_pixel
//   res      out  valid/ready       mse_q16, psnr_q8, identical, count_overflow
// pixels are taken one per cycle while the queue has room; squaring and accumulation run in two stages
// a frame end enters a four-deep queue; the back end takes one frame at a time
// and runs it through the bit-serial divider (one quotient bit a cycle)
// pix stalls only when the queue holds three frames or more; res is a held output register
// arst_n clears the accumulator, the queue and the back end state machine
module image_mse_psnr import imp_pkg::*; #(
	parameter int PIXEL_COUNT_BITS = 24,
	parameter int LOG_TABLE_BITS   = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	imp_pix_if.sink   pix,
	imp_res_if.source res
);

	localparam int QW = 2 * PIXEL_COUNT_BITS + 20;

	logic          push;
	logic          pop;
	logic [QW-1:0] wframe;
	logic [QW-1:0] rframe;
	queue_stat_t   qstat;

	imp_front #(.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)) u_front (
		.clk, .arst_n, .pix, .qstat, .push, .frame(wframe)
	);

	imp_fifo #(.W(QW)) u_fifo (
		.clk, .arst_n, .push, .wdata(wframe), .pop, .rdata(rframe), .stat(qstat)
	);

	imp_back #(
		.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS),
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_back (
		.clk, .arst_n, .qstat, .frame(rframe), .pop, .res
	);

endmodule

[src/imp_fifo.sv]
// short frame queue between the accumulator and the divide/log unit
module imp_fifo import imp_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output queue_stat_t  stat
);

	logic [W-1:0]      mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rdata      = mem_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	// one slot stays free for a frame end still in the squaring stage
	assign stat.room  = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));

`ifndef SYNTH
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q != QCNT_W'(QUEUE_DEPTH))
		else $error("frame queue overrun");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("frame queue underrun");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && pop |=> $stable(cnt_q))
		else $error("queue count moved on push with pop");
`endif

endmodule

[src/imp_front.sv]
// pixel front end: squared differences, frame accumulation and frame push
module imp_front import imp_pkg::*; #(
	parameter int PIXEL_COUNT_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	imp_pix_if.sink       pix,
	input  queue_stat_t   qstat,
	output logic          push,
	output logic [PIXEL_COUNT_BITS+18+PIXEL_COUNT_BITS+1:0] frame
);

	localparam int SUMW = PIXEL_COUNT_BITS + 18;
	localparam int CNTW = PIXEL_COUNT_BITS + 1;
	localparam logic [CNTW-1:0] CNT_FULL = CNTW'(1) << PIXEL_COUNT_BITS;

	logic            accept;
	logic [7:0]      d_b, d_g, d_r;
	logic [17:0]     sq;
	logic            v_s1;
	logic            last_s1;
	logic [17:0]     sq_s1;
	logic [SUMW-1:0] sum_q, sum_n;
	logic [CNTW-1:0] cnt_q, cnt_n;
	logic            ovf_q, ovf_n;

	assign pix.ready = qstat.room;
	assign accept    = pix.valid && pix.ready;

	assign d_b = (pix.first_blue > pix.second_blue) ? pix.first_blue - pix.second_blue
		: pix.second_blue - pix.first_blue;
	assign d_g = (pix.first_green > pix.second_green) ? pix.first_green - pix.second_green
		: pix.second_green - pix.first_green;
	assign d_r = (pix.first_red > pix.second_red) ? pix.first_red - pix.second_red
		: pix.second_red - pix.first_red;
	assign sq = 18'({8'd0, d_b} * {8'd0, d_b}) + 18'({8'd0, d_g} * {8'd0, d_g})
		+ 18'({8'd0, d_r} * {8'd0, d_r});

	always_comb begin
		sum_n = sum_q;
		cnt_n = cnt_q;
		ovf_n = ovf_q;
		if (cnt_q == CNT_FULL) begin
			ovf_n = 1'b1;
		end else begin
			sum_n = sum_q + SUMW'(sq_s1);
			cnt_n = cnt_q + 1'b1;
		end
	end

	assign push  = v_s1 && last_s1;
	assign frame = {sum_n, cnt_n, ovf_n};

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1   <= sq;
			last_s1 <= pix.last_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (v_s1) begin
				if (last_s1) begin
					sum_q <= '0;
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
					ovf_q <= ovf_n;
				end
			end
		end
	end

endmodule

[src/imp_back.sv]
// frame back end: mse division, log2 lookup, psnr scaling and result register
module imp_back import imp_pkg::*; #(
	parameter int PIXEL_COUNT_BITS = 24,
	parameter int LOG_TABLE_BITS   = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_stat_t   qstat,
	input  logic [PIXEL_COUNT_BITS+18+PIXEL_COUNT_BITS+1:0] frame,
	output logic          pop,
	imp_res_if.source     res
);

	localparam int SUMW  = PIXEL_COUNT_BITS + 18;
	localparam int CNTW  = PIXEL_COUNT_BITS + 1;
	localparam int DIVW  = PIXEL_COUNT_BITS + 3;
	localparam int DVDW  = SUMW + 16;
	localparam int DCW   = $clog2(DVDW);
	localparam int TBL_N = 1 << LOG_TABLE_BITS;

	typedef enum logic [2:0] {IDLE, DIV, LOG_POS, LOG_SUB, MUL, FIN} state_t;

	state_t                    state_q;
	logic [SUMW-1:0]           f_sum;
	logic [CNTW-1:0]           f_cnt;
	logic                      f_ovf;
	logic [DVDW-1:0]           dvd_q;
	logic [DIVW-1:0]           dvsr_q;
	logic [DIVW-1:0]           rem_q;
	logic [DIVW:0]             trial;
	logic [31:0]               quo_q;
	logic [DCW-1:0]            dcnt_q;
	logic                      ident_q;
	logic                      ovf_q;
	logic [31:0]               lv;
	logic [4:0]                lpos;
	logic [4:0]                pos_q;
	logic [LOG_TABLE_BITS-1:0] lidx;
	logic [LOG_TABLE_BITS-1:0] idx_q;
	logic [15:0]               tab [TBL_N];
	logic [20:0]               lm;
	logic [20:0]               d_q;
	logic [38:0]               prod_q;
	logic [39:0]               rnd;
	logic [14:0]               psnr;
	logic                      out_v_q;
	logic                      load;

	for (genvar g = 0; g < TBL_N; g++) begin : g_tab
		localparam logic [15:0] ENTRY = table_entry(g, LOG_TABLE_BITS);
		assign tab[g] = ENTRY;
	end

	assign {f_sum, f_cnt, f_ovf} = frame;
	assign pop   = (state_q == IDLE) && !qstat.empty;
	assign trial = {rem_q, dvd_q[DVDW-1]};

	// leading one of the truncated mse, floored at one
	always_comb begin
		lv   = (quo_q == '0) ? 32'd1 : quo_q;
		lpos = '0;
		for (int i = 1; i < 32; i++) begin
			if (lv[i]) lpos = 5'(i);
		end
		lidx = LOG_TABLE_BITS'({lv, {LOG_TABLE_BITS{1'b0}}} >> lpos);
	end

	assign lm   = {pos_q, 16'b0} + 21'(tab[idx_q]);
	assign rnd  = 40'(prod_q) + (40'd1 << 23);
	assign psnr = ident_q ? PSNR_IDENTICAL_Q8
		: ((rnd[39:24] > 16'(PSNR_MAX_Q8)) ? PSNR_MAX_Q8 : rnd[38:24]);
	assign load = (state_q == FIN) && (!out_v_q || res.ready);

	always_ff @(posedge clk) begin
		case (state_q)
			IDLE: begin
				dvd_q   <= {f_sum, 16'b0};
				dvsr_q  <= DIVW'(f_cnt) + (DIVW'(f_cnt) << 1);
				rem_q   <= '0;
				quo_q   <= '0;
				dcnt_q  <= DCW'(DVDW - 1);
				ident_q <= (f_sum == '0);
				ovf_q   <= f_ovf;
			end
			DIV: begin
				dvd_q  <= dvd_q << 1;
				dcnt_q <= dcnt_q - 1'b1;
				if (trial >= {1'b0, dvsr_q}) begin
					rem_q <= DIVW'(trial - {1'b0, dvsr_q});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= trial[DIVW-1:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			LOG_POS: begin
				pos_q <= lpos;
				idx_q <= lidx;
			end
			LOG_SUB: begin
				d_q <= (LOG_TOP_Q16 > lm) ? LOG_TOP_Q16 - lm : '0;
			end
			MUL: begin
				prod_q <= 39'(d_q) * 39'(TEN_LOG10_2_Q16);
			end
			default: begin
			end
		endcase
		if (load) begin
			res.mse_q16        <= quo_q;
			res.psnr_q8        <= psnr;
			res.identical      <= ident_q;
			res.count_overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (load) out_v_q <= 1'b1;
			else if (res.ready) out_v_q <= 1'b0;
			case (state_q)
				IDLE:    if (!qstat.empty) state_q <= DIV;
				DIV:     if (dcnt_q == '0) state_q <= LOG_POS;
				LOG_POS: state_q <= LOG_SUB;
				LOG_SUB: state_q <= MUL;
				MUL:     state_q <= FIN;
				FIN:     if (load) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assign res.valid = out_v_q;

`ifndef SYNTH
	a_ident_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.identical |-> res.mse_q16 == '0 && res.psnr_q8 == PSNR_IDENTICAL_Q8)
		else $error("identical result with nonzero mse or wrong psnr");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == DIV)
		else $error("frame popped without starting the divide");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !res.ready |=> out_v_q && $stable(res.mse_q16))
		else $error("stalled result changed");
`endif

endmodule

[tb/sv/testbench.sv]
// testbench for image_mse_psnr: directed table and random frames checked against a predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import imp_pkg::*;

	localparam int PCB = 24;
	localparam int LTB = 8;
	localparam int DRAIN_CYCLES = 2 * PCB + 39 + 20;

	typedef struct packed {
		logic [31:0] mse_q16;
		logic [14:0] psnr_q8;
		logic        identical;
		logic        count_overflow;
	} frame_res_t;

	typedef struct {
		logic [7:0] fb, fg, fr, sb, sg, sr;
		logic       last;
		logic       has_res;
		frame_res_t res;
	} pix_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	imp_pix_if pix ();
	imp_res_if res ();

	image_mse_psnr #(.PIXEL_COUNT_BITS(PCB), .LOG_TABLE_BITS(LTB)) uut (
		.clk(clk), .arst_n(arst_n), .pix(pix.sink), .res(res.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [41:0] sq_sum;
	logic [24:0] px_count;
	logic        ovf_seen;
	frame_res_t  frame_results_q[$];
	int          mismatches = 0;
	int          frames_done = 0;
	bit          stim_done = 0;

	function automatic logic [15:0] log_frac(input logic [63:0] m_in);
		logic [63:0] m;
		logic [15:0] r;
		m = m_in;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			r = {r[14:0], 1'b0};
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] log2_of(input logic [31:0] v);
		int p;
		logic [31:0] idx;
		p = 0;
		while (p < 31 && (v >> (p + 1)) != 0)
			p++;
		if (p >= LTB)
			idx = (v >> (p - LTB)) & ((32'd1 << LTB) - 1);
		else
			idx = (v << (LTB - p)) & ((32'd1 << LTB) - 1);
		return 64'(p) * 65536 + 64'(log_frac(((64'd1 << LTB) + 64'(idx)) << (30 - LTB)));
	endfunction

	function automatic logic [15:0] sqd(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = a > b ? a - b : b - a;
		return d * d;
	endfunction

	// advance the accumulator by one pixel; returns 1 with the frame result on a last pixel
	function automatic bit accumulate_pixel(input pix_row_t row, output frame_res_t fr);
		logic [63:0] top, lm, d, q, mse64;
		fr = '0;
		if (px_count >= (25'd1 << PCB))
			ovf_seen = 1'b1;
		else begin
			sq_sum += 42'(sqd(row.fb, row.sb)) + 42'(sqd(row.fg, row.sg))
				+ 42'(sqd(row.fr, row.sr));
			px_count++;
		end
		if (!row.last)
			return 0;
		mse64 = ({22'd0, sq_sum} << 16) / (64'd3 * px_count);
		fr.mse_q16 = mse64[31:0];
		if (sq_sum == 0) begin
			fr.identical = 1'b1;
			fr.psnr_q8 = 15'd25600;
		end else begin
			top = 64'd15 * 65536 + 64'(log_frac(64'd65025 << 15)) + 64'd16 * 65536;
			lm = log2_of(fr.mse_q16 != 0 ? fr.mse_q16 : 32'd1);
			d = top > lm ? top - lm : 0;
			q = (d * 64'd197283 + (64'd1 << 23)) >> 24;
			fr.psnr_q8 = q > 32767 ? 15'd32767 : q[14:0];
		end
		fr.count_overflow = ovf_seen;
		sq_sum = '0;
		px_count = '0;
		ovf_seen = 1'b0;
		return 1;
	endfunction

	task automatic send_pixel(input pix_row_t row);
		frame_res_t fr;
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.first_blue <= row.fb;
		pix.first_green <= row.fg;
		pix.first_red <= row.fr;
		pix.second_blue <= row.sb;
		pix.second_green <= row.sg;
		pix.second_red <= row.sr;
		pix.last_pixel <= row.last;
		do @(posedge clk); while (!pix.ready);
		if (accumulate_pixel(row, fr)) begin
			if (row.has_res && fr !== row.res) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row disagrees with predictor: %h vs %h", row.res, fr);
			end
			frame_results_q.push_back(fr);
		end
	endtask

	function automatic pix_row_t mk(input int fb, fg, fr, sb, sg, sr, input bit last);
		pix_row_t r;
		r.fb = 8'(fb); r.fg = 8'(fg); r.fr = 8'(fr);
		r.sb = 8'(sb); r.sg = 8'(sg); r.sr = 8'(sr);
		r.last = last;
		r.has_res = 0;
		r.res = '0;
		return r;
	endfunction

	function automatic pix_row_t mk_res(input pix_row_t r, input frame_res_t e);
		r.has_res = 1;
		r.res = e;
		return r;
	endfunction

	function automatic pix_row_t rand_pix(input bit last, input int spread);
		pix_row_t r;
		int base[3];
		for (int i = 0; i < 3; i++)
			base[i] = $urandom_range(0, 255);
		r = mk(base[0], base[1], base[2], base[0], base[1], base[2], last);
		r.sb = 8'(spread >= 256 ? $urandom_range(0, 255) : base[0] ^ $urandom_range(0, spread));
		r.sg = 8'(spread >= 256 ? $urandom_range(0, 255) : base[1] ^ $urandom_range(0, spread));
		r.sr = 8'(spread >= 256 ? $urandom_range(0, 255) : base[2] ^ $urandom_range(0, spread));
		return r;
	endfunction

	// result sink
	always @(posedge clk) begin
		frame_res_t got, exp_r;
		if (arst_n && res.valid && res.ready) begin
			got = {res.mse_q16, res.psnr_q8, res.identical, res.count_overflow};
			if (frame_results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				exp_r = frame_results_q.pop_front();
				frames_done++;
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("frame %0d: exp mse %h psnr %h id %b ovf %b, got %h %h %b %b",
							frames_done, exp_r.mse_q16, exp_r.psnr_q8, exp_r.identical,
							exp_r.count_overflow, got.mse_q16, got.psnr_q8, got.identical,
							got.count_overflow);
				end
			end
		end
	end

	// receiver stalls: res.ready may be held low before each result, with runs of no stall
	initial begin
		int w;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
			if (w != 0) begin
				res.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	initial begin
		#50ms;
		$display("image_mse_psnr: mismatch");
		$finish;
	end

	initial begin
		pix_row_t dir_rows[$];
		frame_res_t e;
		int sent, flen, spread, wait_cycles;
		pix.valid = 1'b0;
		pix.first_blue = '0; pix.first_green = '0; pix.first_red = '0;
		pix.second_blue = '0; pix.second_green = '0; pix.second_red = '0;
		pix.last_pixel = 1'b0;
		sq_sum = '0; px_count = '0; ovf_seen = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identical single pixel: psnr forced to 100 dB
		e = '{mse_q16: 32'd0, psnr_q8: 15'd25600, identical: 1'b1, count_overflow: 1'b0};
		dir_rows.push_back(mk_res(mk(0, 0, 0, 0, 0, 0, 1), e));
		// full-scale difference on every channel: mse = 65025 in Q16.16
		e = '{mse_q16: 32'd65025 << 16, psnr_q8: 15'd0, identical: 1'b0,
			count_overflow: 1'b0};
		dir_rows.push_back(mk_res(mk(255, 255, 255, 0, 0, 0, 1), e));
		dir_rows.push_back(mk(0, 0, 0, 255, 255, 255, 1));
		dir_rows.push_back(mk(255, 0, 255, 0, 255, 0, 1));
		dir_rows.push_back(mk(8'haa, 8'h55, 8'hf0, 8'h55, 8'haa, 8'h0f, 1));
		dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 1));
		dir_rows.push_back(mk(128, 64, 32, 128, 64, 32, 0));
		dir_rows.push_back(mk(200, 100, 50, 200, 100, 50, 0));
		dir_rows.push_back(mk(7, 7, 7, 7, 7, 7, 1));
		// small mse: one unit difference spread over a longer frame
		for (int i = 0; i < 14; i++)
			dir_rows.push_back(mk(i, 3 * i, 9, i, 3 * i, 9, 0));
		dir_rows.push_back(mk(0, 1, 0, 0, 0, 0, 1));
		foreach (dir_rows[i])
			send_pixel(dir_rows[i]);

		// pause until every expected frame has come out
		pix.valid <= 1'b0;
		while (frame_results_q.size() != 0) @(posedge clk);

		sent = 0;
		while (sent < 850) begin
			flen = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			case ($urandom_range(0, 3))
				0: spread = 0;
				1: spread = 1;
				2: spread = 15;
				default: spread = 256;
			endcase
			for (int i = 0; i < flen; i++) begin
				send_pixel(rand_pix(i == flen - 1, spread));
				sent++;
			end
			if ($urandom_range(0, 40) == 0) begin
				pix.valid <= 1'b0;
				while (frame_results_q.size() != 0) @(posedge clk);
			end
		end
		pix.valid <= 1'b0;

		wait_cycles = 0;
		while (frame_results_q.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && frame_results_q.size() == 0)
			$display("image_mse_psnr: match");
		else
			$display("image_mse_psnr: mismatch");
		$finish;
	end
endmodule
